// ===== design/ordered_id_list_defines.svh =====
// Assertion macros for the ordered id list.
`ifndef ORDERED_ID_LIST_DEFINES_SVH
`define ORDERED_ID_LIST_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define OIL_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ordered_id_list: same-cycle check failed");
`define OIL_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ordered_id_list: next-cycle check failed");
`else
`define OIL_ASSERT_IMP(lbl, ante, cons)
`define OIL_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== design/oil_pkg.sv =====
`timescale 1ns / 1ps
package oil_pkg;

   localparam int DEPTH   = 64;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int SUM_W   = CNT_W + 1;
   localparam int ID_W    = 32;
   localparam int OP_W    = 3;
   localparam int ENTRY_W = 7;

   localparam logic [OP_W-1:0] OP_APPEND   = 3'd0;
   localparam logic [OP_W-1:0] OP_REMOVE   = 3'd1;
   localparam logic [OP_W-1:0] OP_CONTAINS = 3'd2;
   localparam logic [OP_W-1:0] OP_INDEX    = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR    = 3'd4;

endpackage

// ===== design/oil_ram.sv =====
`timescale 1ns / 1ps
module oil_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/ordered_id_list.sv =====
`timescale 1ns / 1ps
// Channel | Direction | Handshake             | Word
// req     | in        | req_valid / req_ready | req_opcode, req_id_value
// rsp     | out       | rsp_valid / rsp_ready | rsp_hit, rsp_overflow, rsp_entry_count
//
// Append, index, clear, unused opcodes and lookups on an empty list go from idle straight
// to the done state, which loads the rsp register and returns to idle for the next accept.
// Contains and remove scan the store one entry at a time (one read port, registered read);
// remove then moves each later entry down one place with a read and a write of the RAM.
// req_ready is high only while the sequencer is idle; a finished word waits in the
// sequencer until the rsp register is free. Reset (synchronous) empties the list.
`include "ordered_id_list_defines.svh"
module ordered_id_list
   import oil_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [OP_W-1:0]    req_opcode,
   input  logic [ID_W-1:0]    req_id_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_hit,
   output logic               rsp_overflow,
   output logic [ENTRY_W-1:0] rsp_entry_count
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD,
      ST_CMP,
      ST_SH_RD,
      ST_SH_WR,
      ST_DONE
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [OP_W-1:0]     op_ff, op_in;
   logic [ID_W-1:0]     key_ff, key_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic                hit_ff, hit_in;
   logic                ovf_ff, ovf_in;
   logic                rsp_hit_ff, rsp_hit_in;
   logic                rsp_ovf_ff, rsp_ovf_in;
   logic [ENTRY_W-1:0]  rsp_cnt_ff, rsp_cnt_in;

   logic                ram_wr_en;
   logic [ADDR_W-1:0]   ram_wr_addr;
   logic [ID_W-1:0]     ram_wr_data;
   logic                ram_rd_en;
   logic [ADDR_W-1:0]   ram_rd_addr;
   logic [ID_W-1:0]     ram_rd_data;

   logic [SUM_W-1:0]    addr_p1;
   logic [SUM_W-1:0]    addr_p2;
   logic [SUM_W-1:0]    count_x;
   logic                accept;

   oil_ram #(
      .WIDTH (ID_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign accept  = req_valid & req_ready;
   assign addr_p1 = SUM_W'(addr_ff) + SUM_W'(1);
   assign addr_p2 = SUM_W'(addr_ff) + SUM_W'(2);
   assign count_x = SUM_W'(count_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      op_in        = op_ff;
      key_in       = key_ff;
      addr_in      = addr_ff;
      hit_in       = hit_ff;
      ovf_in       = ovf_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = addr_ff;
      ram_wr_data  = ram_rd_data;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = addr_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_opcode;
               key_in   = req_id_value;
               addr_in  = '0;
               hit_in   = 1'b0;
               ovf_in   = 1'b0;
               state_in = ST_DONE;
               case (req_opcode)
                  OP_APPEND: begin
                     if (count_x < SUM_W'(DEPTH)) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = ADDR_W'(count_ff);
                        ram_wr_data = req_id_value;
                        count_in    = count_ff + CNT_W'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  OP_REMOVE, OP_CONTAINS: begin
                     if (count_ff != '0) begin
                        state_in = ST_RD;
                     end
                  end
                  OP_INDEX: begin
                     hit_in = (req_id_value < ID_W'(count_ff));
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = addr_ff;
            state_in    = ST_CMP;
         end
         ST_CMP: begin
            if (ram_rd_data == key_ff) begin
               hit_in = 1'b1;
               if (op_ff == OP_CONTAINS) begin
                  state_in = ST_DONE;
               end else if (addr_p1 < count_x) begin
                  state_in = ST_SH_RD;
               end else begin
                  count_in = count_ff - CNT_W'(1);
                  state_in = ST_DONE;
               end
            end else if (addr_p1 < count_x) begin
               addr_in  = ADDR_W'(addr_p1);
               state_in = ST_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SH_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = ADDR_W'(addr_p1);
            state_in    = ST_SH_WR;
         end
         ST_SH_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = addr_ff;
            ram_wr_data = ram_rd_data;
            if (addr_p2 < count_x) begin
               addr_in  = ADDR_W'(addr_p1);
               state_in = ST_SH_RD;
            end else begin
               count_in = count_ff - CNT_W'(1);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = hit_ff;
               rsp_ovf_in   = ovf_ff;
               rsp_cnt_in   = ENTRY_W'(count_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff      <= op_in;
      key_ff     <= key_in;
      addr_ff    <= addr_in;
      hit_ff     <= hit_in;
      ovf_ff     <= ovf_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_ovf_ff <= rsp_ovf_in;
      rsp_cnt_ff <= rsp_cnt_in;
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_overflow    = rsp_ovf_ff;
   assign rsp_entry_count = rsp_cnt_ff;

   `OIL_ASSERT_IMP(a_count_range, 1'b1, count_ff <= CNT_W'(DEPTH))
   `OIL_ASSERT_IMP(a_ovf_full, rsp_valid_ff && rsp_ovf_ff, rsp_cnt_ff == ENTRY_W'(DEPTH))
   `OIL_ASSERT_NXT(a_busy_count_step, state_ff != ST_IDLE, (count_ff == $past(count_ff)) || (count_ff == $past(count_ff) - CNT_W'(1)))
   `OIL_ASSERT_IMP(a_shift_in_range, state_ff == ST_SH_WR, addr_p1 < count_x)

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
   import oil_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED_FIRST = OP_CLEAR + 1'b1;
   localparam logic [OP_W-1:0] OP_UNUSED_LAST  = '1;
   localparam int unsigned     DRAIN_CYCLES    = 300;

   typedef struct packed {
      logic               hit;
      logic               overflow;
      logic [ENTRY_W-1:0] entry_count;
   } list_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [OP_W-1:0]    req_opcode = OP_CLEAR;
   logic [ID_W-1:0]    req_id_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_hit;
   logic               rsp_overflow;
   logic [ENTRY_W-1:0] rsp_entry_count;

   logic [ID_W-1:0]   list_ids [DEPTH];
   int unsigned       list_len = 0;
   list_result_type   pending_results [$];
   int unsigned       errors = 0;
   bit                req_idle_on = 1'b1;
   bit                rsp_idle_on = 1'b1;
   int unsigned       rsp_hold_cycles = 0;

   ordered_id_list dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_id_value    (req_id_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hit         (rsp_hit),
      .rsp_overflow    (rsp_overflow),
      .rsp_entry_count (rsp_entry_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #25_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic int unsigned gap_cycles();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Applies one word to the list image and returns what the block must answer.
   function automatic list_result_type list_apply(input logic [OP_W-1:0] op,
                                                  input logic [ID_W-1:0] val);
      list_result_type res;
      int              pos;
      res = '0;
      pos = -1;
      case (op)
         OP_APPEND: begin
            if (list_len < DEPTH) begin
               list_ids[list_len] = val;
               list_len++;
            end else begin
               res.overflow = 1'b1;
            end
         end
         OP_REMOVE, OP_CONTAINS: begin
            for (int i = 0; i < list_len; i++) begin
               if (pos < 0 && list_ids[i] == val) pos = i;
            end
            res.hit = (pos >= 0);
            if (op == OP_REMOVE && pos >= 0) begin
               for (int i = pos; i + 1 < list_len; i++) list_ids[i] = list_ids[i + 1];
               list_len--;
            end
         end
         OP_INDEX: res.hit = (val < list_len);
         OP_CLEAR: list_len = 0;
         default: ;
      endcase
      res.entry_count = list_len[ENTRY_W-1:0];
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t: %s", $time, msg);
      errors++;
   endtask

   task automatic send_word(input logic [OP_W-1:0] op, input logic [ID_W-1:0] val);
      if (req_idle_on && $urandom_range(0, 99) < 30) begin
         req_valid <= 1'b0;
         repeat (gap_cycles()) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_opcode   <= op;
      req_id_value <= val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(list_apply(op, val));
   endtask

   always @(posedge clock) begin : rsp_check
      list_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("rsp word with nothing pending");
         end else begin
            want = pending_results.pop_front();
            if (rsp_hit !== want.hit)
               report_mismatch($sformatf("hit %b, want %b", rsp_hit, want.hit));
            if (rsp_overflow !== want.overflow)
               report_mismatch($sformatf("overflow %b, want %b", rsp_overflow,
                                         want.overflow));
            if (rsp_entry_count !== want.entry_count)
               report_mismatch($sformatf("entry_count %0d, want %0d", rsp_entry_count,
                                         want.entry_count));
         end
      end
   end

   initial begin : rsp_drive
      int unsigned n;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            n = rsp_hold_cycles;
            rsp_hold_cycles = 0;
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end else if (rsp_idle_on && $urandom_range(0, 99) < 30) begin
            rsp_ready <= 1'b0;
            repeat (gap_cycles()) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   task automatic wait_drained();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic test_directed_ops();
      send_word(OP_CONTAINS, '0);
      send_word(OP_REMOVE, '1);
      send_word(OP_INDEX, '0);
      send_word(OP_INDEX, '1);
      for (int op = OP_UNUSED_FIRST; op <= OP_UNUSED_LAST; op++) send_word(OP_W'(op), '1);
      send_word(OP_CLEAR, '0);
      send_word(OP_APPEND, '1);
      send_word(OP_APPEND, '0);
      send_word(OP_APPEND, '1);
      send_word(OP_APPEND, 32'h8000_0001);
      send_word(OP_CONTAINS, '1);
      send_word(OP_CONTAINS, 32'h0000_0001);
      send_word(OP_INDEX, 32'd3);
      send_word(OP_INDEX, 32'd4);
      send_word(OP_REMOVE, '1);
      send_word(OP_CONTAINS, '1);
      send_word(OP_REMOVE, 32'h1234_5678);
      send_word(OP_REMOVE, 32'h8000_0001);
      send_word(OP_UNUSED_LAST, 32'h5555_aaaa);
      send_word(OP_CLEAR, '1);
      send_word(OP_INDEX, '0);
   endtask

   task automatic test_full_list();
      logic [ID_W-1:0] first_id;
      send_word(OP_CLEAR, '0);
      first_id = $urandom();
      send_word(OP_APPEND, first_id);
      while (list_len < DEPTH) send_word(OP_APPEND, $urandom());
      send_word(OP_APPEND, '1);
      send_word(OP_APPEND, '0);
      send_word(OP_INDEX, DEPTH - 1);
      send_word(OP_INDEX, DEPTH);
      send_word(OP_CONTAINS, list_ids[DEPTH - 1]);
      send_word(OP_REMOVE, list_ids[DEPTH / 2]);
      send_word(OP_APPEND, first_id);
      send_word(OP_APPEND, $urandom());
      send_word(OP_REMOVE, first_id);
      send_word(OP_REMOVE, list_ids[list_len - 1]);
      send_word(OP_CONTAINS, first_id);
      send_word(OP_CLEAR, '0);
   endtask

   // Receiver stops for a long stretch while words keep coming.
   task automatic test_backpressure();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      rsp_hold_cycles = 250;
      for (int i = 0; i < 16; i++) begin
         if (i % 3 == 2) send_word(OP_CONTAINS, $urandom_range(0, 7));
         else send_word(OP_APPEND, $urandom_range(0, 7));
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   task automatic random_word(input int unsigned bias, const ref logic [ID_W-1:0] pool [8]);
      int unsigned     r;
      int unsigned     grow;
      int unsigned     shrink;
      logic [ID_W-1:0] val;
      case (bias)
         0:       begin grow = 50; shrink = 15; end
         1:       begin grow = 15; shrink = 45; end
         default: begin grow = 35; shrink = 30; end
      endcase
      val = ($urandom_range(0, 99) < 80) ? pool[$urandom_range(0, 7)] : $urandom();
      r = $urandom_range(0, 99);
      if (r < grow) send_word(OP_APPEND, val);
      else if (r < grow + shrink) send_word(OP_REMOVE, val);
      else if (r < grow + shrink + 20) send_word(OP_CONTAINS, val);
      else if (r < grow + shrink + 32)
         send_word(OP_INDEX, ($urandom_range(0, 9) < 7) ? $urandom_range(0, DEPTH + 6)
                                                        : $urandom());
      else if (r < grow + shrink + 34) send_word(OP_CLEAR, val);
      else send_word(OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)), val);
   endtask

   task automatic test_random_traffic(input int unsigned words);
      logic [ID_W-1:0] pool [8];
      int unsigned     sent;
      int unsigned     bias;
      int unsigned     run;
      sent = 0;
      while (sent < words) begin
         foreach (pool[i]) pool[i] = $urandom();
         if ($urandom_range(0, 4) == 0) pool[0] = '0;
         if ($urandom_range(0, 4) == 0) pool[1] = '1;
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         bias = $urandom_range(0, 2);
         run = $urandom_range(40, 150);
         for (int i = 0; i < run && sent < words; i++) begin
            random_word(bias, pool);
            sent++;
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed_ops();
      test_full_list();
      test_backpressure();
      test_random_traffic(1330);
      req_valid <= 1'b0;
      wait_drained();
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
